FILE: src/lbs_pkg.sv
package lbs_pkg;

    localparam int MAX_BONES  = 64;
    localparam int FRAC_BITS  = 16;

    localparam int WORD_W     = 32;
    localparam int BONE_W     = 6;
    localparam int ROW_W      = 2;
    localparam int NUM_ROWS   = 4;
    localparam int NUM_AXES   = 3;

    // palette address and range check
    localparam int BONE_AW    = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
    localparam int BONE_CMP_W = 9;

    // front queue
    localparam int QDEPTH     = 4;
    localparam int Q_AW       = $clog2(QDEPTH);
    localparam int Q_CW       = Q_AW + 1;

    // datapath widths
    localparam int PROD_W     = 2 * WORD_W;
    localparam int SUM_W      = PROD_W - FRAC_BITS + 2;
    localparam int ACC_W      = SUM_W + 1;
    localparam int ROW_DATA_W = NUM_AXES * WORD_W;

    // stream packing
    localparam int S_TDATA_W  = 136;
    localparam int M_TDATA_W  = 96;
    localparam int BONE_LSB   = 0;
    localparam int ROW_LSB    = BONE_LSB + BONE_W;
    localparam int C_LSB      = ROW_LSB + ROW_W;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_INFL = 1'b1;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic {
        KIND_LOAD,
        KIND_INFL
    } t_kind;

    typedef struct packed {
        t_kind                     kind;
        logic                      bone_ok;
        logic [BONE_W-1:0]         bone;
        logic [ROW_W-1:0]          row;
        t_word [NUM_ROWS-1:0]      c;
        logic                      last;
    } t_item;

endpackage

FILE: src/lbs_row_ram.sv
module lbs_row_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/lbs_front.sv
module lbs_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [lbs_pkg::S_TDATA_W-1:0]  i_data,
    input  logic                           i_mode,
    input  logic                           i_last,
    output logic                           o_q_valid,
    output lbs_pkg::t_item                 o_q_item,
    input  logic                           i_q_pop
);

    lbs_pkg::t_item              w_item;
    logic                        w_keep;
    logic                        w_push;
    lbs_pkg::t_item              r_mem [lbs_pkg::QDEPTH];
    logic [lbs_pkg::Q_AW-1:0]    r_wr_ptr;
    logic [lbs_pkg::Q_AW-1:0]    r_rd_ptr;
    logic [lbs_pkg::Q_CW-1:0]    r_count;
    logic [lbs_pkg::Q_CW-1:0]    n_count;

    always_comb begin
        w_item.kind    = (i_mode == lbs_pkg::MODE_INFL) ? lbs_pkg::KIND_INFL
                                                        : lbs_pkg::KIND_LOAD;
        w_item.bone    = i_data[lbs_pkg::BONE_LSB +: lbs_pkg::BONE_W];
        w_item.row     = i_data[lbs_pkg::ROW_LSB +: lbs_pkg::ROW_W];
        w_item.bone_ok = lbs_pkg::BONE_CMP_W'(w_item.bone)
                         < lbs_pkg::BONE_CMP_W'(lbs_pkg::MAX_BONES);
        for (int k = 0; k < lbs_pkg::NUM_ROWS; k++) begin
            w_item.c[k] = i_data[lbs_pkg::C_LSB + k*lbs_pkg::WORD_W +: lbs_pkg::WORD_W];
        end
        w_item.last    = i_last;
        // a load beyond the palette is dropped here
        w_keep         = (w_item.kind == lbs_pkg::KIND_INFL) || w_item.bone_ok;
    end

    assign o_ready   = (r_count != lbs_pkg::Q_CW'(lbs_pkg::QDEPTH));
    assign w_push    = i_valid && o_ready && w_keep;
    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    always_comb begin
        n_count = r_count;
        case ({w_push, i_q_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

FILE: src/lbs_back.sv
module lbs_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  lbs_pkg::t_item                 i_q_item,
    output logic                           o_q_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [lbs_pkg::M_TDATA_W-1:0]  o_data
);

    logic                                w_en;
    logic [lbs_pkg::BONE_AW-1:0]         w_addr;
    logic [lbs_pkg::ROW_DATA_W-1:0]      w_rd [lbs_pkg::NUM_ROWS];

    // stage 1: palette rows read
    logic                                r1_v;
    logic                                r1_ok;
    logic                                r1_last;
    lbs_pkg::t_word [lbs_pkg::NUM_ROWS-1:0] r1_w;
    // stage 2: raw products
    logic                                r2_v;
    logic                                r2_last;
    logic signed [lbs_pkg::PROD_W-1:0]   r2_p [lbs_pkg::NUM_AXES][lbs_pkg::NUM_ROWS];
    logic signed [lbs_pkg::PROD_W-1:0]   n2_p [lbs_pkg::NUM_AXES][lbs_pkg::NUM_ROWS];
    // stage 3: per-axis sums
    logic                                r3_v;
    logic                                r3_last;
    logic signed [lbs_pkg::SUM_W-1:0]    r3_sum [lbs_pkg::NUM_AXES];
    logic signed [lbs_pkg::SUM_W-1:0]    n3_sum [lbs_pkg::NUM_AXES];
    // accumulator and result
    lbs_pkg::t_word                      r_acc [lbs_pkg::NUM_AXES];
    lbs_pkg::t_word                      n_acc [lbs_pkg::NUM_AXES];
    logic                                r_out_v;
    lbs_pkg::t_word                      r_out [lbs_pkg::NUM_AXES];

    function automatic lbs_pkg::t_word sat_word(input logic signed [lbs_pkg::ACC_W-1:0] v);
        logic signed [lbs_pkg::ACC_W-1:0] hi;
        logic signed [lbs_pkg::ACC_W-1:0] lo;
        hi = lbs_pkg::ACC_W'(lbs_pkg::t_word'(32'sh7fff_ffff));
        lo = lbs_pkg::ACC_W'(lbs_pkg::t_word'(32'sh8000_0000));
        if (v > hi) begin
            return lbs_pkg::t_word'(32'sh7fff_ffff);
        end else if (v < lo) begin
            return lbs_pkg::t_word'(32'sh8000_0000);
        end
        return lbs_pkg::t_word'(v[lbs_pkg::WORD_W-1:0]);
    endfunction

    // whole back pipeline moves only when the result register can take a value
    assign w_en    = !r_out_v || i_ready;
    assign o_q_pop = w_en && i_q_valid;
    assign w_addr  = lbs_pkg::BONE_AW'(i_q_item.bone);

    for (genvar r = 0; r < lbs_pkg::NUM_ROWS; r++) begin : g_row
        lbs_row_ram #(
            .WIDTH (lbs_pkg::ROW_DATA_W),
            .DEPTH (lbs_pkg::MAX_BONES)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (o_q_pop && (i_q_item.kind == lbs_pkg::KIND_LOAD)
                      && (i_q_item.row == lbs_pkg::ROW_W'(r))),
            .i_waddr (w_addr),
            .i_wdata (i_q_item.c[lbs_pkg::NUM_AXES-1:0]),
            .i_re    (w_en),
            .i_raddr (w_addr),
            .o_rdata (w_rd[r])
        );
    end

    always_comb begin
        for (int k = 0; k < lbs_pkg::NUM_AXES; k++) begin
            for (int r = 0; r < lbs_pkg::NUM_ROWS; r++) begin
                if (r1_ok) begin
                    n2_p[k][r] = $signed(w_rd[r][k*lbs_pkg::WORD_W +: lbs_pkg::WORD_W])
                                 * $signed(r1_w[r]);
                end else begin
                    n2_p[k][r] = '0;
                end
            end
        end
    end

    // arithmetic shift floors each product before the exact sum
    always_comb begin
        for (int k = 0; k < lbs_pkg::NUM_AXES; k++) begin
            n3_sum[k] = '0;
            for (int r = 0; r < lbs_pkg::NUM_ROWS; r++) begin
                n3_sum[k] = n3_sum[k]
                            + lbs_pkg::SUM_W'(r2_p[k][r] >>> lbs_pkg::FRAC_BITS);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < lbs_pkg::NUM_AXES; k++) begin
            n_acc[k] = sat_word(lbs_pkg::ACC_W'(r_acc[k]) + lbs_pkg::ACC_W'(r3_sum[k]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_w    <= i_q_item.c;
            r1_ok   <= i_q_item.bone_ok;
            r1_last <= i_q_item.last;
            r2_p    <= n2_p;
            r2_last <= r1_last;
            r3_sum  <= n3_sum;
            r3_last <= r2_last;
            if (r3_v && r3_last) begin
                r_out <= n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r_out_v <= 1'b0;
            for (int k = 0; k < lbs_pkg::NUM_AXES; k++) begin
                r_acc[k] <= '0;
            end
        end else if (w_en) begin
            r1_v    <= i_q_valid && (i_q_item.kind == lbs_pkg::KIND_INFL);
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r_out_v <= r3_v && r3_last;
            if (r3_v) begin
                for (int k = 0; k < lbs_pkg::NUM_AXES; k++) begin
                    r_acc[k] <= r3_last ? '0 : n_acc[k];
                end
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = {r_out[2], r_out[1], r_out[0]};

endmodule

FILE: src/linear_blend_skinning.sv
// channel   dir  handshake                  payload
// s_axis    in   tvalid/tready              tdata: bone, row, c0..c3; tuser: mode; tlast: last
// m_axis    out  tvalid/tready              tdata: vert_x, vert_y, vert_z
//
// one item a cycle sustained while m_axis takes results; with the queue empty an
// influence passes the queue, then the palette read, multiply and sum registers,
// and is accumulated into the result register
// the palette is four row memories of one read and one write port each, so all rows
// of a bone matrix are read in the same cycle
// a four-entry queue keeps taking items while a result waits on m_axis
// synchronous active-low reset clears the queue, valids and accumulator; the
// palette is not cleared and must be loaded before use
module linear_blend_skinning (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // bone[5:0], row[7:6], c0[39:8], c1[71:40], c2[103:72], c3[135:104]
    input  logic [lbs_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // mode[0]
    input  logic                           i_s_axis_tuser,
    input  logic                           i_s_axis_tlast,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // vert_x[31:0], vert_y[63:32], vert_z[95:64]
    output logic [lbs_pkg::M_TDATA_W-1:0]  o_m_axis_tdata
);

    logic             w_q_valid;
    lbs_pkg::t_item   w_q_item;
    logic             w_pop;

    lbs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_data    (i_s_axis_tdata),
        .i_mode    (i_s_axis_tuser),
        .i_last    (i_s_axis_tlast),
        .o_q_valid (w_q_valid),
        .o_q_item  (w_q_item),
        .i_q_pop   (w_pop)
    );

    lbs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_q_pop   (w_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_data    (o_m_axis_tdata)
    );

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("queue popped while empty");

    a_stall_holds_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !w_pop)
        else $error("queue popped while result stalled");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

FILE: test/linear_blend_skinning_test.sv
module linear_blend_skinning_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [lbs_pkg::NUM_ROWS-1:0][lbs_pkg::WORD_W-1:0] t_quad;
    typedef logic [lbs_pkg::NUM_AXES-1:0][lbs_pkg::WORD_W-1:0] t_vertex;

    typedef struct packed {
        logic                       mode;
        logic                       last;
        logic [lbs_pkg::BONE_W-1:0] bone;
        logic [lbs_pkg::ROW_W-1:0]  row;
        t_quad                      c;
    } t_skin_item;

    localparam int    TOTAL_ITEMS = 1100;
    localparam int    CYCLE_LIMIT = 200000;
    localparam int    DRAIN       = 20;
    localparam int    CALM_FROM   = 600;
    localparam int    CALM_TO     = 1100;
    localparam longint SAT_HI     = 64'sd2147483647;
    localparam longint SAT_LO     = -64'sd2147483648;

    localparam logic [lbs_pkg::WORD_W-1:0] Q_ONE   = 32'h0001_0000;
    localparam logic [lbs_pkg::WORD_W-1:0] W_MAX   = 32'h7fff_ffff;
    localparam logic [lbs_pkg::WORD_W-1:0] W_MIN   = 32'h8000_0000;
    localparam logic [lbs_pkg::WORD_W-1:0] W_ONES  = 32'hffff_ffff;
    localparam logic [lbs_pkg::WORD_W-1:0] W_FIVES = 32'h5555_5555;
    localparam logic [lbs_pkg::WORD_W-1:0] W_AS    = 32'haaaa_aaaa;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          s_valid = 1'b0;
    logic [lbs_pkg::S_TDATA_W-1:0] s_data  = '0;
    logic                          s_mode  = 1'b0;
    logic                          s_last  = 1'b0;
    logic                          m_ready = 1'b0;
    logic                          s_ready;
    logic                          m_valid;
    logic [lbs_pkg::M_TDATA_W-1:0] m_data;

    // generator side: which rows of each bone have been queued for loading
    logic [lbs_pkg::NUM_ROWS-1:0] rows_queued [lbs_pkg::MAX_BONES];

    // predictor state
    t_quad           palette [lbs_pkg::MAX_BONES][lbs_pkg::NUM_ROWS];
    lbs_pkg::t_word  vert_acc [lbs_pkg::NUM_AXES];

    t_skin_item pending[$];
    t_vertex    expected_verts[$];
    t_skin_item on_bus;
    int         items_taken = 0;
    int         bad_results = 0;
    int         cycle_count = 0;

    wire calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

    linear_blend_skinning uut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_mode),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic void queue_item(logic mode, logic [lbs_pkg::BONE_W-1:0] bone,
                                       logic [lbs_pkg::ROW_W-1:0] row, t_quad c,
                                       logic last);
        t_skin_item it;
        it.mode = mode;
        it.bone = bone;
        it.row  = row;
        it.c    = c;
        it.last = last;
        if (mode == lbs_pkg::MODE_LOAD)
            rows_queued[bone][row] = 1'b1;
        pending.push_back(it);
    endfunction

    // mostly modest Q16.16 values, with extremes and raw noise mixed in
    function automatic logic [lbs_pkg::WORD_W-1:0] rand_word();
        case ($urandom_range(31))
            0: return W_MIN;
            1: return W_MAX;
            2: return '0;
            3: return W_ONES;
            4: return W_FIVES;
            5: return W_AS;
            6, 7: return $urandom;
            default: return 32'($urandom_range(524288)) - 32'd262144;
        endcase
    endfunction

    function automatic t_quad rand_quad();
        return {rand_word(), rand_word(), rand_word(), rand_word()};
    endfunction

    function automatic logic [lbs_pkg::BONE_W-1:0] loaded_bone();
        logic [lbs_pkg::BONE_W-1:0] b;
        do
            b = lbs_pkg::BONE_W'($urandom_range(lbs_pkg::MAX_BONES - 1));
        while (rows_queued[b] != '1);
        return b;
    endfunction

    // bit-exact skinning step: floor-shifted products, one saturation per influence
    function automatic void skin_apply(t_skin_item it);
        longint sum;
        items_taken++;
        if (it.mode == lbs_pkg::MODE_LOAD) begin
            if (it.bone < lbs_pkg::MAX_BONES)
                palette[it.bone][it.row] = it.c;
            return;
        end
        if (it.bone < lbs_pkg::MAX_BONES) begin
            for (int k = 0; k < lbs_pkg::NUM_AXES; k++) begin
                sum = longint'(vert_acc[k]);
                for (int r = 0; r < lbs_pkg::NUM_ROWS; r++)
                    sum += (longint'(lbs_pkg::t_word'(palette[it.bone][r][k]))
                            * longint'(lbs_pkg::t_word'(it.c[r]))) >>> lbs_pkg::FRAC_BITS;
                if (sum > SAT_HI)
                    vert_acc[k] = lbs_pkg::t_word'(SAT_HI);
                else if (sum < SAT_LO)
                    vert_acc[k] = lbs_pkg::t_word'(SAT_LO);
                else
                    vert_acc[k] = lbs_pkg::t_word'(sum);
            end
        end
        if (it.last) begin
            expected_verts.push_back({vert_acc[2], vert_acc[1], vert_acc[0]});
            for (int k = 0; k < lbs_pkg::NUM_AXES; k++)
                vert_acc[k] = '0;
        end
    endfunction

    // driver: holds an item until taken, then maybe idles before the next
    always @(posedge i_clk) begin
        bit send;
        if (s_valid && s_ready)
            skin_apply(on_bus);
        send = s_valid && !s_ready;
        if (!send && rst_n && pending.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
            on_bus = pending.pop_front();
            send   = 1'b1;
        end
        s_valid <= send;
        s_data  <= {on_bus.c, on_bus.row, on_bus.bone};
        s_mode  <= on_bus.mode;
        s_last  <= on_bus.last;
    end

    always @(posedge i_clk) begin
        t_vertex want;
        t_vertex got;
        if (rst_n && m_valid && m_ready) begin
            got = m_data;
            if (expected_verts.size() == 0) begin
                $display("%0t: vertex %h arrived with none expected", $time, got);
                bad_results++;
            end else begin
                want = expected_verts.pop_front();
                for (int k = 0; k < lbs_pkg::NUM_AXES; k++)
                    if (got[k] !== want[k]) begin
                        $display("%0t: axis %0d expected %h, got %h",
                                 $time, k, want[k], got[k]);
                        bad_results++;
                    end
            end
        end
        m_ready <= calm || ($urandom_range(99) >= 20);
    end

    initial begin
        logic [lbs_pkg::BONE_W-1:0] b;
        logic [lbs_pkg::ROW_W-1:0]  r0;
        logic [lbs_pkg::ROW_W-1:0]  step;
        int                         n;

        for (int i = 0; i < lbs_pkg::MAX_BONES; i++) begin
            rows_queued[i] = '0;
            for (int r = 0; r < lbs_pkg::NUM_ROWS; r++)
                palette[i][r] = '0;
        end
        for (int k = 0; k < lbs_pkg::NUM_AXES; k++)
            vert_acc[k] = '0;
        on_bus = '0;

        // bone 0 full of extremes, a load carrying last among them
        queue_item(lbs_pkg::MODE_LOAD, 0, 0, {W_ONES, Q_ONE, W_MIN, W_MAX}, 1'b0);
        queue_item(lbs_pkg::MODE_LOAD, 0, 1, {W_MAX, 32'h0, W_AS, W_FIVES}, 1'b1);
        queue_item(lbs_pkg::MODE_LOAD, 0, 2, {32'h0, W_MIN, 32'h1, W_ONES}, 1'b0);
        queue_item(lbs_pkg::MODE_LOAD, 0, 3,
                   {W_MIN, W_MAX, 32'hfffe_8000, 32'h0001_8000}, 1'b0);
        // bone 63 as identity, loaded out of order
        queue_item(lbs_pkg::MODE_LOAD, 63, 3, {Q_ONE, 32'h0, 32'h0, 32'h0}, 1'b0);
        queue_item(lbs_pkg::MODE_LOAD, 63, 1, {32'h0, 32'h0, Q_ONE, 32'h0}, 1'b1);
        queue_item(lbs_pkg::MODE_LOAD, 63, 0, {W_AS, 32'h0, 32'h0, Q_ONE}, 1'b0);
        queue_item(lbs_pkg::MODE_LOAD, 63, 2, {32'h0, Q_ONE, 32'h0, 32'h0}, 1'b0);

        queue_item(lbs_pkg::MODE_INFL, 63, 0,
                   {Q_ONE, 32'h0003_0000, 32'hfffe_0000, 32'h0001_8000}, 1'b1);
        queue_item(lbs_pkg::MODE_INFL, 0, 1, {W_MAX, W_MAX, W_MAX, W_MAX}, 1'b1);
        queue_item(lbs_pkg::MODE_INFL, 0, 2, {W_MIN, W_MIN, W_MIN, W_MIN}, 1'b1);
        // negative products check the floor rounding
        queue_item(lbs_pkg::MODE_INFL, 0, 3, {W_ONES, W_ONES, W_ONES, W_ONES}, 1'b1);
        queue_item(lbs_pkg::MODE_INFL, 0, 0, {32'h1, 32'h1, 32'h1, 32'h1}, 1'b1);
        queue_item(lbs_pkg::MODE_INFL, 63, 2,
                   {32'h0, 32'h0002_0000, 32'h0000_4000, 32'hffff_0000}, 1'b0);
        queue_item(lbs_pkg::MODE_INFL, 0, 1, {32'h0, Q_ONE, 32'h0, 32'h0000_8000}, 1'b0);
        queue_item(lbs_pkg::MODE_INFL, 63, 0, {W_FIVES, W_AS, Q_ONE, 32'hfff8_0000}, 1'b1);
        queue_item(lbs_pkg::MODE_INFL, 0, 3, {32'h0, 32'h0, 32'h0, 32'h0}, 1'b1);
        // reload a row, then use it straight away
        queue_item(lbs_pkg::MODE_LOAD, 63, 1, {W_ONES, 32'h0, 32'h0002_0000, 32'h0}, 1'b0);
        queue_item(lbs_pkg::MODE_INFL, 63, 0, {32'h0, 32'h0, Q_ONE, 32'h0}, 1'b1);
        // saturate high mid-vertex, then pull back down
        queue_item(lbs_pkg::MODE_INFL, 0, 0, {W_MAX, W_MAX, W_MAX, W_MAX}, 1'b0);
        queue_item(lbs_pkg::MODE_INFL, 0, 0, {W_MIN, W_MIN, W_MIN, W_MIN}, 1'b1);

        while (pending.size() < TOTAL_ITEMS) begin
            case ($urandom_range(9))
                0, 1: begin
                    // whole matrix in a rotated row order
                    b    = lbs_pkg::BONE_W'($urandom_range(lbs_pkg::MAX_BONES - 1));
                    r0   = lbs_pkg::ROW_W'($urandom_range(3));
                    step = $urandom_range(1) ? 2'd1 : 2'd3;
                    for (int k = 0; k < lbs_pkg::NUM_ROWS; k++)
                        queue_item(lbs_pkg::MODE_LOAD, b, lbs_pkg::ROW_W'(r0 + k * step),
                                   rand_quad(), $urandom_range(9) == 0);
                end
                2: begin
                    // a lone row, possibly leaving a bone part-loaded
                    queue_item(lbs_pkg::MODE_LOAD,
                               lbs_pkg::BONE_W'($urandom_range(lbs_pkg::MAX_BONES - 1)),
                               lbs_pkg::ROW_W'($urandom_range(3)), rand_quad(),
                               $urandom_range(1) == 1);
                end
                default: begin
                    n = ($urandom_range(9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
                    for (int k = 0; k < n; k++)
                        queue_item(lbs_pkg::MODE_INFL, loaded_bone(),
                                   lbs_pkg::ROW_W'($urandom_range(3)),
                                   rand_quad(), k == n - 1);
                end
            endcase
        end
        n = pending.size();

        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;

        while (items_taken != n || expected_verts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (bad_results == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
src/lbs_pkg.sv
src/lbs_row_ram.sv
src/lbs_front.sv
src/lbs_back.sv
src/linear_blend_skinning.sv
test/linear_blend_skinning_test.sv
